// ===== rtl/sidw_pkg.sv =====
// sidw_pkg: shared widths, codes, cell control and state types for the
// signed integer to digit-register write block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sidw_pkg;

  localparam int DIGITS      = 8;
  localparam int MAX_DEVICES = 8;

  localparam int DEV_W   = 3;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 4;
  localparam int REG_W   = 4;
  localparam int CODE_W  = 4;

  localparam int LIMIT_W = 5;
  localparam int IDX_W   = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  // four binary bits enter the decimal cells per cycle
  localparam int STEP_BITS   = 4;
  localparam int CONV_CYCLES = VALUE_W / STEP_BITS;
  localparam int CONV_W      = (CONV_CYCLES > 1) ? $clog2(CONV_CYCLES) : 1;
  localparam int BCD_CELLS   = 10;

  localparam logic [CODE_W-1:0] CODE_ZERO  = 4'd0;
  localparam logic [CODE_W-1:0] CODE_MINUS = 4'b1010;
  localparam logic [CODE_W-1:0] CODE_BLANK = 4'h0F;

  typedef logic [CODE_W-1:0] bcd_t;

  typedef struct packed {
    logic clr;
    logic conv;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_MINUS,
    ST_DIGIT
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/sidw_ifs.sv =====
// sidw_ifs: valid/ready channel interfaces for input and result words.
// Depends on sidw_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface sidw_in_if;
  import sidw_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [DEV_W-1:0]          device_id;
  logic signed [VALUE_W-1:0] value;
  logic                      zero_fill;

  modport source (output valid, device_id, value, zero_fill, input ready);
  modport sink   (input valid, device_id, value, zero_fill, output ready);
endinterface

interface sidw_out_if;
  import sidw_pkg::*;

  logic              valid;
  logic              ready;
  logic [DEV_W-1:0]  target_device;
  logic [REG_W-1:0]  digit_register;
  logic [CODE_W-1:0] digit_code;
  logic              last;

  modport source (output valid, target_device, digit_register, digit_code, last,
                  input ready);
  modport sink   (input valid, target_device, digit_register, digit_code, last,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/sidw_digit_cell.sv =====
// sidw_digit_cell: one decimal digit of the shift-and-add-3 converter chain.
// Depends on sidw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sidw_digit_cell (
  input  wire logic                             clk,
  input  wire sidw_pkg::cell_ctrl_t             ctrl,
  input  wire logic [sidw_pkg::STEP_BITS-1:0]   carry_in,
  output      logic [sidw_pkg::STEP_BITS-1:0]   carry_out,
  input  wire sidw_pkg::bcd_t                   upper_digit,
  output      sidw_pkg::bcd_t                   digit
);
  import sidw_pkg::*;

  bcd_t digit_r;
  bcd_t digit_nxt;
  bcd_t conv_val;

  always_comb begin
    bcd_t v;
    v = digit_r;
    carry_out = '0;
    for (int s = 0; s < STEP_BITS; s++) begin
      if (v >= 4'd5) begin
        v = v + 4'd3;
      end
      carry_out[s] = v[3];
      v = {v[2:0], carry_in[s]};
    end
    conv_val = v;
  end

  always_comb begin
    digit_nxt = digit_r;
    if (ctrl.clr) begin
      digit_nxt = '0;
    end else if (ctrl.conv) begin
      digit_nxt = conv_val;
    end else if (ctrl.shift) begin
      digit_nxt = upper_digit;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  assign digit = digit_r;

endmodule
`default_nettype wire

// ===== rtl/signed_int_to_digit_writes_top.sv =====
// signed_int_to_digit_writes_top: turns a signed value into digit-register
// writes. Depends on sidw_pkg, sidw_ifs and sidw_digit_cell.
//
//   port     dir  contents
//   in_word  in   device_id, value, zero_fill
//   out_word out  target_device, digit_register, digit_code, last
//   cfg_*    in   instance_count write
//
// One item at a time. Conversion moves the 32 bits through the decimal
// cell chain, four bits per cycle, then one write per cycle while out_word
// is ready: 1 to 8 writes per item.
// An item for an unknown device is taken and gives nothing.
// Reset clears the control state and instance_count; stalls on out_word hold.
`timescale 1ns / 1ps
`default_nettype none
module signed_int_to_digit_writes_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  sidw_in_if.sink                           in_word,
  sidw_out_if.source                        out_word,
  input  wire logic                         cfg_we,
  input  wire logic [sidw_pkg::COUNT_W-1:0] cfg_wdata
);
  import sidw_pkg::*;

  state_t state_r, state_nxt;

  logic [COUNT_W-1:0] count_r;
  logic [LIMIT_W-1:0] limit;
  logic               dev_ok;
  logic               in_acc;
  logic               out_acc;

  logic [VALUE_W-1:0] mag_r, mag_nxt;
  logic [DEV_W-1:0]   dev_r;
  logic               neg_r, zero_r, lz_r;
  logic [IDX_W-1:0]   last_idx_r;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [CONV_W-1:0]  conv_cnt_r, conv_cnt_nxt;

  cell_ctrl_t         ctrl;
  logic [STEP_BITS-1:0] bin_bits;
  logic [STEP_BITS-1:0] carry [BCD_CELLS];
  bcd_t               dig [BCD_CELLS+1];
  logic               any_nz;
  logic               digit_last;

  assign limit  = (count_r > COUNT_W'(MAX_DEVICES)) ? LIMIT_W'(MAX_DEVICES)
                                                    : LIMIT_W'(count_r);
  assign dev_ok = LIMIT_W'(in_word.device_id) < limit;

  assign in_word.ready = (state_r == ST_IDLE);
  assign in_acc  = in_word.valid && in_word.ready;
  assign out_acc = out_word.valid && out_word.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_we) begin
      count_r <= cfg_wdata;
    end
  end

  // binary bits enter the chain most significant first
  always_comb begin
    for (int s = 0; s < STEP_BITS; s++) begin
      bin_bits[s] = mag_r[VALUE_W-1-s];
    end
  end

  assign dig[BCD_CELLS] = '0;

  for (genvar i = 0; i < BCD_CELLS; i++) begin : g_cell
    sidw_digit_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .carry_in    ((i == 0) ? bin_bits : carry[(i == 0) ? 0 : i-1]),
      .carry_out   (carry[i]),
      .upper_digit (dig[i+1]),
      .digit       (dig[i])
    );
  end

  always_comb begin
    any_nz = 1'b0;
    for (int i = 0; i < BCD_CELLS; i++) begin
      any_nz = any_nz | (dig[i] != '0);
    end
  end

  assign digit_last = (idx_r == last_idx_r) || (zero_r && !lz_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && dev_ok) state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (conv_cnt_r == CONV_W'(CONV_CYCLES-1)) begin
          state_nxt = neg_r ? ST_MINUS : ST_DIGIT;
        end
      end
      ST_MINUS: begin
        if (out_acc) state_nxt = (DIGITS == 1) ? ST_IDLE : ST_DIGIT;
      end
      ST_DIGIT: begin
        if (out_acc && digit_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl                    = '0;
    out_word.valid          = 1'b0;
    out_word.digit_register = REG_W'(idx_r) + REG_W'(1);
    out_word.digit_code     = CODE_ZERO;
    out_word.last           = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        ctrl.clr = in_acc && dev_ok;
      end
      ST_CONV: begin
        ctrl.conv = 1'b1;
      end
      ST_MINUS: begin
        out_word.valid          = 1'b1;
        out_word.digit_register = REG_W'(DIGITS);
        out_word.digit_code     = CODE_MINUS;
        out_word.last           = (DIGITS == 1);
      end
      ST_DIGIT: begin
        out_word.valid      = 1'b1;
        out_word.last       = digit_last;
        ctrl.shift          = out_acc;
        if (any_nz) begin
          out_word.digit_code = dig[0];
        end else if (lz_r || zero_r) begin
          out_word.digit_code = CODE_ZERO;
        end else begin
          out_word.digit_code = CODE_BLANK;
        end
      end
      default: ;
    endcase
  end

  assign out_word.target_device = dev_r;

  always_comb begin
    conv_cnt_nxt = conv_cnt_r;
    idx_nxt      = idx_r;
    mag_nxt      = mag_r;
    if (in_acc) begin
      conv_cnt_nxt = '0;
      idx_nxt      = '0;
      mag_nxt      = in_word.value[VALUE_W-1] ? (~in_word.value + VALUE_W'(1))
                                              : in_word.value;
    end else if (state_r == ST_CONV) begin
      conv_cnt_nxt = conv_cnt_r + CONV_W'(1);
      mag_nxt      = mag_r << STEP_BITS;
    end else if (state_r == ST_DIGIT && out_acc) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    conv_cnt_r <= conv_cnt_nxt;
    idx_r      <= idx_nxt;
    mag_r      <= mag_nxt;
    if (in_acc) begin
      dev_r      <= in_word.device_id;
      neg_r      <= in_word.value[VALUE_W-1];
      zero_r     <= (in_word.value == '0);
      lz_r       <= in_word.zero_fill;
      last_idx_r <= in_word.value[VALUE_W-1] ? IDX_W'(DIGITS-2) : IDX_W'(DIGITS-1);
    end
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_word.ready |-> !out_word.valid)
    else $error("input taken while writes pending");

  a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_word.valid && out_word.ready && out_word.last |=> in_word.ready)
    else $error("block not idle after final write");

  a_top_cell_no_carry: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CONV |-> carry[BCD_CELLS-1] == '0)
    else $error("decimal chain overflow");

  a_minus_position: assert property (@(posedge clk) disable iff (!rst_n)
    out_word.valid && out_word.digit_code == CODE_MINUS
      |-> out_word.digit_register == REG_W'(DIGITS))
    else $error("minus sign off the leftmost digit");
`endif

endmodule
`default_nettype wire

// ===== dv/tb_signed_int_to_digit_writes_top.sv =====
// tb_signed_int_to_digit_writes_top: self-checking bench for the signed value to
// digit-register write block, with directed, device-limit and random phases.
// Depends on sidw_pkg, sidw_ifs and the signed_int_to_digit_writes_top RTL.
`timescale 1ns / 1ps
module tb_signed_int_to_digit_writes_top;
  import sidw_pkg::*;

  typedef struct packed {
    logic [DEV_W-1:0]  device;
    logic [REG_W-1:0]  digit_reg;
    logic [CODE_W-1:0] code;
    logic              last;
  } digit_write_t;

  localparam int SETTLE_CYCLES = 20;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [COUNT_W-1:0] cfg_wdata;

  sidw_in_if  in_if ();
  sidw_out_if out_if ();

  signed_int_to_digit_writes_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_if),
    .out_word (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  digit_write_t       pending_writes[$];
  digit_write_t       seen_write;
  digit_write_t       due_write;
  logic [COUNT_W-1:0] attached_count;
  int                 write_errors;
  int                 out_hold;
  bit                 steady_in;
  bit                 steady_out;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_signed_int_to_digit_writes_top NOT OK");
    $finish;
  end

  function automatic void queue_write(input digit_write_t w);
    pending_writes = {pending_writes, w};
  endfunction

  function automatic void predict_digit_writes(input logic [DEV_W-1:0] dev,
                                               input logic [VALUE_W-1:0] value,
                                               input logic lz);
    int                limit;
    int                slots;
    int                pos;
    logic [VALUE_W-1:0] mag;
    logic [CODE_W-1:0] fill;
    limit = (attached_count > MAX_DEVICES) ? MAX_DEVICES : int'(attached_count);
    if (int'(dev) >= limit) return;
    fill  = lz ? CODE_ZERO : CODE_BLANK;
    mag   = value;
    slots = DIGITS;
    pos   = 0;
    if (value == '0) begin
      slots = lz ? DIGITS : 1;
      for (pos = 0; pos < slots; pos++)
        queue_write(digit_write_t'{dev, REG_W'(pos + 1), CODE_ZERO, 1'b0});
    end else begin
      if (value[VALUE_W-1]) begin
        mag   = '0 - value;
        slots = DIGITS - 1;
        queue_write(digit_write_t'{dev, REG_W'(DIGITS), CODE_MINUS, 1'b0});
      end
      while (mag != '0 && pos < slots) begin
        queue_write(digit_write_t'{dev, REG_W'(pos + 1), CODE_W'(mag % 10), 1'b0});
        mag = mag / 10;
        pos++;
      end
      for (; pos < slots; pos++)
        queue_write(digit_write_t'{dev, REG_W'(pos + 1), fill, 1'b0});
    end
    pending_writes[pending_writes.size() - 1].last = 1'b1;
  endfunction

  function automatic void note_error(input string what);
    write_errors++;
    if (write_errors <= 10)
      $display("%s: exp dev %0d reg %0d code %0d last %0d, got dev %0d reg %0d code %0d last %0d",
               what, due_write.device, due_write.digit_reg, due_write.code, due_write.last,
               seen_write.device, seen_write.digit_reg, seen_write.code, seen_write.last);
  endfunction

  // result side: hold ready low for a drawn number of cycles after each word
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready <= (out_hold == 0);
      if (out_hold > 0) out_hold--;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      seen_write = '{out_if.target_device, out_if.digit_register, out_if.digit_code,
                     out_if.last};
      out_hold   = steady_out ? 0 : $urandom_range(0, 7);
      if (pending_writes.size() == 0) begin
        due_write = 'x;
        note_error("unexpected write");
      end else begin
        due_write = pending_writes.pop_front();
        if (seen_write.device !== due_write.device ||
            seen_write.digit_reg !== due_write.digit_reg ||
            seen_write.code !== due_write.code ||
            seen_write.last !== due_write.last)
          note_error("write mismatch");
      end
    end
  end

  task automatic send_word(input logic [DEV_W-1:0] dev, input logic [VALUE_W-1:0] value,
                           input logic lz, input bit drain_first = 1'b0);
    int gap;
    gap = steady_in ? 0 : $urandom_range(0, 7);
    if (drain_first || gap > 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      while (drain_first && pending_writes.size() != 0) @(negedge clk);
      if (gap > 1) repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid         <= 1'b1;
    in_if.device_id     <= dev;
    in_if.value         <= value;
    in_if.zero_fill     <= lz;
    do @(posedge clk); while (!in_if.ready);
    predict_digit_writes(dev, value, lz);
  endtask

  task automatic settle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_instance_count(input logic [COUNT_W-1:0] count);
    settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    @(negedge clk);
    cfg_we         <= 1'b0;
    attached_count  = count;
  endtask

  function automatic logic [VALUE_W-1:0] random_value();
    case ($urandom_range(0, 6))
      0: return $urandom;
      1: return $urandom_range(0, 9);
      2: return $urandom_range(0, 99999999);
      3: return '0 - VALUE_W'($urandom_range(1, 9999999));
      4: return $urandom_range(100000000, 32'h7fff_ffff);
      5: return '0 - VALUE_W'($urandom_range(10000000, 32'h8000_0000));
      default: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return 32'h8000_0000;
          2: return 32'h7fff_ffff;
          default: return 32'hffff_ffff;
        endcase
      end
    endcase
  endfunction

  task automatic test_directed();
    set_instance_count(4'd8);
    send_word(3'd0, 32'd0, 1'b0);
    send_word(3'd7, 32'd0, 1'b1);
    send_word(3'd1, -32'sd1, 1'b0);
    send_word(3'd2, -32'sd1, 1'b1);
    send_word(3'd3, 32'h7fff_ffff, 1'b0);
    send_word(3'd4, 32'h8000_0000, 1'b1);
    send_word(3'd5, 32'd12345678, 1'b0);
    send_word(3'd6, 32'd123456789, 1'b1);
    send_word(3'd0, -32'sd1234567, 1'b0);
    send_word(3'd1, -32'sd12345678, 1'b1);
    send_word(3'd2, 32'd5, 1'b1);
    send_word(3'd3, 32'd100, 1'b0);
    send_word(3'd4, -32'sd5, 1'b1);
    send_word(3'd5, 32'd10000000, 1'b0);
    send_word(3'd6, 32'h5555_5555, 1'b1);
    send_word(3'd7, 32'haaaa_aaaa, 1'b0);
  endtask

  task automatic test_device_limit();
    set_instance_count(4'd0);
    send_word(3'd0, 32'd77, 1'b1);
    send_word(3'd7, -32'sd77, 1'b0);
    set_instance_count(4'd15);
    send_word(3'd7, -32'sd9, 1'b0);
    set_instance_count(4'd1);
    send_word(3'd0, 32'd42, 1'b0);
    send_word(3'd1, 32'd42, 1'b1);
    send_word(3'd7, -32'sd42, 1'b1);
    set_instance_count(4'd9);
    send_word(3'd7, 32'd123, 1'b1);
  endtask

  task automatic test_random();
    logic [COUNT_W-1:0] counts[5];
    int                 limit;
    logic [DEV_W-1:0]   dev;
    counts = '{4'd8, 4'd5, 4'd1, 4'd12, 4'd3};
    foreach (counts[p]) begin
      set_instance_count(counts[p]);
      limit = (counts[p] > MAX_DEVICES) ? MAX_DEVICES : int'(counts[p]);
      for (int i = 0; i < 60; i++) begin
        if (i % 16 == 0) begin
          steady_in  = ($urandom_range(0, 3) == 0);
          steady_out = ($urandom_range(0, 3) == 0);
        end
        if ($urandom_range(0, 9) < 8) dev = DEV_W'($urandom_range(0, limit - 1));
        else dev = DEV_W'($urandom_range(0, 7));
        send_word(dev, random_value(), 1'($urandom_range(0, 1)),
                  (p == 0 && i == 10) || $urandom_range(0, 39) == 0);
      end
    end
    steady_in  = 1'b0;
    steady_out = 1'b0;
  endtask

  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    in_if.valid         = 1'b0;
    in_if.device_id     = '0;
    in_if.value         = '0;
    in_if.zero_fill     = 1'b0;
    attached_count      = '0;
    write_errors        = 0;
    out_hold            = 0;
    steady_in           = 1'b0;
    steady_out          = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_device_limit();
    test_random();
    settle();

    if (write_errors == 0 && pending_writes.size() == 0) begin
      $display("tb_signed_int_to_digit_writes_top OK");
    end else begin
      $display("tb_signed_int_to_digit_writes_top NOT OK");
    end
    $finish;
  end

endmodule
